FILE: src/fplcg_pkg.sv
// Shared types and constants for the full-period LCG index path.
// Used by fplcg_div and full_period_lcg_index_path; no dependencies.
package fplcg_pkg;

    localparam int SIZE_W  = 24;               // path size, index, increment
    localparam int SEED_W  = 31;               // start seed
    localparam int MULT_W  = 25;               // multiplier
    localparam int DIV_W   = 32;               // serial divider dividend width
    localparam int CFG_W   = 31;               // widest config register
    localparam int CNT_W   = $clog2(SIZE_W);   // mulmod bit counter
    localparam int INC_DIV = 3;                // increment search starts at S/3

    localparam logic CFG_PATH_SIZE  = 1'b0;
    localparam logic CFG_START_SEED = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quo;
        logic [SIZE_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAD_CHK,
        ST_RAD_DIV,
        ST_RAD_TAIL,
        ST_RAD_FIN,
        ST_INC_DIV3,
        ST_INC_CHK,
        ST_PRI_CHK,
        ST_PRI_DIV,
        ST_SEED,
        ST_EMIT,
        ST_MUL_M,
        ST_MUL_K,
        ST_MUL_DBL,
        ST_MUL_ADD,
        ST_FIN
    } t_state;

endpackage

FILE: src/fplcg_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on fplcg_pkg.
module fplcg_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fplcg_pkg::t_div_req i_req,
    output fplcg_pkg::t_div_rsp o_rsp
);
    import fplcg_pkg::*;

    localparam int DC_W = $clog2(DIV_W);

    logic              r_busy;
    logic              r_done;
    logic [DC_W-1:0]   r_cnt;
    logic [SIZE_W-1:0] r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [SIZE_W-1:0] r_dsr;

    logic [SIZE_W:0] rem_sh;
    logic [SIZE_W:0] diff;
    logic            ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_W-1]};
        diff   = rem_sh - {1'b0, r_dsr};
        ge     = rem_sh >= {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DC_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_rsp = '{done: r_done, quo: r_quo, rem: r_rem};

endmodule

FILE: src/full_period_lcg_index_path.sv
// Full-period LCG index path: one index per input transaction.
// Plain step: the accepted request moves to ST_EMIT, which registers the index once the
// result register is free; the next accept follows two serial reductions of multiplier and
// increment on the shared bit-serial divider, a double-and-add mulmod and one final add.
// Restart first factors S and searches the increment, by trial division on that divider.
// Reset is synchronous, active low: size 1, seed 0, generator uninitialized.
module full_period_lcg_index_path #(
    parameter int MAX_SIZE = 10000000
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [fplcg_pkg::CFG_W-1:0]    i_cfg_data,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_restart,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [fplcg_pkg::SIZE_W-1:0]   o_index
);
    import fplcg_pkg::*;

    // trial divisor width: enough for sqrt(MAX_SIZE) + 1
    localparam int PW = ($clog2(MAX_SIZE + 1) + 1) / 2 + 1;

    // config registers
    logic [SIZE_W-1:0] r_path_size;
    logic [SEED_W-1:0] r_seed;

    // control and generator state
    t_state            r_state, n_state;
    logic              r_init, n_init;
    logic              r_out_valid, n_out_valid;
    logic [MULT_W-1:0] r_mult, n_mult;
    logic [SIZE_W-1:0] r_inc, n_inc;
    logic [SIZE_W-1:0] r_cur, n_cur;

    // working registers
    logic [SIZE_W-1:0] r_size, n_size;   // effective size latched per transaction
    logic [SIZE_W-1:0] r_n, n_n;         // remaining cofactor while factoring
    logic [MULT_W-1:0] r_prod, n_prod;   // radical under construction
    logic [PW-1:0]     r_p, n_p;         // trial divisor
    logic              r_hit, n_hit;     // current p already taken into product
    logic [SIZE_W-1:0] r_c, n_c;         // increment candidate
    logic [SIZE_W-1:0] r_m, n_m;         // multiplier mod S
    logic [SIZE_W-1:0] r_k, n_k;         // increment mod S
    logic [SIZE_W-1:0] r_acc, n_acc;     // mulmod accumulator
    logic [SIZE_W-1:0] r_sh, n_sh;       // value bits, MSB first
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SIZE_W-1:0] r_index, n_index;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [SIZE_W-1:0]    eff_size;
    logic [2*PW-1:0]      pp;
    logic [SIZE_W:0]      dbl, add, fin;
    logic [SIZE_W-1:0]    dbl_red, add_red, fin_red;
    logic [MULT_W-1:0]    rad_a;

    fplcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_size <= SIZE_W'(1);
            r_seed      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATH_SIZE:  r_path_size <= i_cfg_data[SIZE_W-1:0];
                CFG_START_SEED: r_seed      <= i_cfg_data[SEED_W-1:0];
                default:        r_seed      <= r_seed;
            endcase
        end
    end

    // datapath helpers
    always_comb begin
        // zero acts as one, oversize saturates
        if (r_path_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (32'(r_path_size) > 32'(MAX_SIZE)) begin
            eff_size = SIZE_W'(MAX_SIZE);
        end else begin
            eff_size = r_path_size;
        end

        pp = r_p * r_p;

        // each sum stays below 2S, so one conditional subtract reduces it
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, r_size}) ? SIZE_W'(dbl - {1'b0, r_size}) : SIZE_W'(dbl);
        add     = {1'b0, r_acc} + {1'b0, r_m};
        add_red = (add >= {1'b0, r_size}) ? SIZE_W'(add - {1'b0, r_size}) : SIZE_W'(add);
        fin     = {1'b0, r_acc} + {1'b0, r_k};
        fin_red = (fin >= {1'b0, r_size}) ? SIZE_W'(fin - {1'b0, r_size}) : SIZE_W'(fin);

        // radical doubled when S is a multiple of four
        rad_a = (r_size[1:0] == 2'b00) ? {r_prod[MULT_W-2:0], 1'b0} : r_prod;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_out_valid = r_out_valid;
        n_mult      = r_mult;
        n_inc       = r_inc;
        n_cur       = r_cur;
        n_size      = r_size;
        n_n         = r_n;
        n_prod      = r_prod;
        n_p         = r_p;
        n_hit       = r_hit;
        n_c         = r_c;
        n_m         = r_m;
        n_k         = r_k;
        n_acc       = r_acc;
        n_sh        = r_sh;
        n_cnt       = r_cnt;
        n_index     = r_index;
        div_req     = '{start: 1'b0, dividend: '0, divisor: r_size};
        o_in_stall  = (r_state != ST_IDLE);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_size = eff_size;
                    if (i_restart || !r_init) begin
                        n_n     = eff_size;
                        n_prod  = MULT_W'(1);
                        n_p     = PW'(2);
                        n_hit   = 1'b0;
                        n_state = ST_RAD_CHK;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_RAD_CHK: begin
                if (32'(pp) > 32'(r_n)) begin
                    n_state = ST_RAD_TAIL;
                end else begin
                    div_req = '{start: 1'b1, dividend: DIV_W'(r_n), divisor: SIZE_W'(r_p)};
                    n_state = ST_RAD_DIV;
                end
            end
            ST_RAD_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem == '0) begin
                        // divide p out completely, count it once
                        if (!r_hit) begin
                            n_prod = MULT_W'(r_prod * r_p);
                        end
                        n_hit   = 1'b1;
                        n_n     = div_rsp.quo[SIZE_W-1:0];
                        div_req = '{start: 1'b1, dividend: div_rsp.quo,
                                    divisor: SIZE_W'(r_p)};
                    end else begin
                        n_hit   = 1'b0;
                        n_p     = r_p + 1'b1;
                        n_state = ST_RAD_CHK;
                    end
                end
            end
            ST_RAD_TAIL: begin
                // leftover cofactor above one is a prime factor
                if (r_n > SIZE_W'(1)) begin
                    n_prod = MULT_W'(r_prod * r_n);
                end
                n_state = ST_RAD_FIN;
            end
            ST_RAD_FIN: begin
                n_mult  = rad_a + 1'b1;
                div_req = '{start: 1'b1, dividend: DIV_W'(r_size),
                            divisor: SIZE_W'(INC_DIV)};
                n_state = ST_INC_DIV3;
            end
            ST_INC_DIV3: begin
                if (div_rsp.done) begin
                    n_c     = div_rsp.quo[SIZE_W-1:0];
                    n_state = ST_INC_CHK;
                end
            end
            ST_INC_CHK: begin
                if (r_c > SIZE_W'(2)) begin
                    n_p     = PW'(2);
                    n_state = ST_PRI_CHK;
                end else begin
                    n_inc   = (r_c < SIZE_W'(2)) ? SIZE_W'(2) : r_c;
                    div_req = '{start: 1'b1, dividend: DIV_W'(r_seed), divisor: r_size};
                    n_state = ST_SEED;
                end
            end
            ST_PRI_CHK: begin
                if (32'(pp) > 32'(r_c)) begin
                    // no divisor found: candidate is prime
                    n_inc   = r_c;
                    div_req = '{start: 1'b1, dividend: DIV_W'(r_seed), divisor: r_size};
                    n_state = ST_SEED;
                end else begin
                    div_req = '{start: 1'b1, dividend: DIV_W'(r_c), divisor: SIZE_W'(r_p)};
                    n_state = ST_PRI_DIV;
                end
            end
            ST_PRI_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem == '0) begin
                        n_c     = r_c - 1'b1;
                        n_state = ST_INC_CHK;
                    end else begin
                        n_p     = r_p + 1'b1;
                        n_state = ST_PRI_CHK;
                    end
                end
            end
            ST_SEED: begin
                if (div_rsp.done) begin
                    n_cur   = div_rsp.rem;
                    n_init  = 1'b1;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // result goes out before the generator advances
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_index     = r_cur;
                    div_req     = '{start: 1'b1, dividend: DIV_W'(r_mult), divisor: r_size};
                    n_state     = ST_MUL_M;
                end
            end
            ST_MUL_M: begin
                if (div_rsp.done) begin
                    n_m     = div_rsp.rem;
                    div_req = '{start: 1'b1, dividend: DIV_W'(r_inc), divisor: r_size};
                    n_state = ST_MUL_K;
                end
            end
            ST_MUL_K: begin
                if (div_rsp.done) begin
                    n_k     = div_rsp.rem;
                    n_acc   = '0;
                    n_sh    = r_cur;
                    n_cnt   = CNT_W'(SIZE_W - 1);
                    n_state = ST_MUL_DBL;
                end
            end
            ST_MUL_DBL: begin
                n_acc   = dbl_red;
                n_state = ST_MUL_ADD;
            end
            ST_MUL_ADD: begin
                if (r_sh[SIZE_W-1]) begin
                    n_acc = add_red;
                end
                n_sh = {r_sh[SIZE_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = ST_MUL_DBL;
                end
            end
            ST_FIN: begin
                n_cur   = fin_red;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
            r_mult      <= MULT_W'(1);
            r_inc       <= '0;
            r_cur       <= '0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
            r_mult      <= n_mult;
            r_inc       <= n_inc;
            r_cur       <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size  <= n_size;
        r_n     <= n_n;
        r_prod  <= n_prod;
        r_p     <= n_p;
        r_hit   <= n_hit;
        r_c     <= n_c;
        r_m     <= n_m;
        r_k     <= n_k;
        r_acc   <= n_acc;
        r_sh    <= n_sh;
        r_cnt   <= n_cnt;
        r_index <= n_index;
    end

    assign o_out_valid = r_out_valid;
    assign o_index     = r_index;

    // advanced value is always reduced below the latched size
    a_cur_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (r_cur < r_size))
        else $error("advanced index not below path size");

    // mulmod accumulator stays reduced throughout the loop
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_DBL || r_state == ST_MUL_ADD) |-> (r_acc < r_size))
        else $error("mulmod accumulator out of range");

    // once initialized the generator never falls back
    a_init_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |=> r_init)
        else $error("initialized flag dropped");

endmodule

FILE: dv/full_period_lcg_index_path_tb.sv
// Testbench for full_period_lcg_index_path: random-gap request and result traffic,
// an in-bench index predictor and a scoreboard on the index stream.
// Depends on fplcg_pkg and the full_period_lcg_index_path RTL only.
module full_period_lcg_index_path_tb;
    import fplcg_pkg::*;

    localparam int unsigned SIZE_CAP     = 10000000;  // block's MAX_SIZE
    localparam int          HOLD_CYCLES  = 400;       // long receiver hold-off
    localparam int          DRAIN_CYCLES = 150;       // longer than one plain step
    localparam int          IDLE_LIMIT   = 2000000;   // watchdog limit, above the worst restart

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = CFG_PATH_SIZE;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_restart = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b1;
    logic [SIZE_W-1:0] o_index;

    full_period_lcg_index_path uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_restart(i_restart),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_index(o_index)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor copy of the configuration and generator state
    logic [SIZE_W-1:0] cfg_size;
    logic [SEED_W-1:0] cfg_seed;
    logic [MULT_W-1:0] gen_mult;
    logic [SIZE_W-1:0] gen_incr;
    logic [SIZE_W-1:0] gen_value;
    logic              gen_ready;

    logic [SIZE_W-1:0] expected_indices[$];
    int                error_count = 0;
    int                idle_cycles = 0;

    // Traffic shaping knobs, changed by the test tasks
    int  max_send_gap = 12;
    int  max_stall_gap = 12;
    bit  hold_request = 1'b0;
    bit  result_taken = 1'b0;

    // ---------------------------------------------------------------------
    // Reference arithmetic for the generator
    // ---------------------------------------------------------------------
    function automatic longint unsigned modulus_of(logic [SIZE_W-1:0] sz);
        longint unsigned s;
        s = sz;
        if (s == 0) s = 1;
        if (s > SIZE_CAP) s = SIZE_CAP;
        return s;
    endfunction

    function automatic bit is_prime_num(longint unsigned n);
        longint unsigned d;
        if (n < 2) return 1'b0;
        for (d = 2; d * d <= n; d++)
            if (n % d == 0) return 1'b0;
        return 1'b1;
    endfunction

    // product of distinct prime factors
    function automatic longint unsigned prime_kernel(longint unsigned n);
        longint unsigned prod, p;
        prod = 1;
        for (p = 2; p * p <= n; p++) begin
            if (n % p == 0) begin
                prod *= p;
                while (n % p == 0) n /= p;
            end
        end
        if (n > 1) prod *= n;
        return prod;
    endfunction

    // Applies one request to the predictor and returns the index it must emit
    function automatic logic [SIZE_W-1:0] next_path_index(bit restart);
        longint unsigned s, a, c;
        logic [SIZE_W-1:0] emitted;
        s = modulus_of(cfg_size);
        if (restart || !gen_ready) begin
            a = prime_kernel(s);
            if (s % 4 == 0) a *= 2;
            gen_mult = MULT_W'(a + 1);
            c = s / INC_DIV;
            while (c > 2 && !is_prime_num(c)) c--;
            if (c < 2) c = 2;
            gen_incr = SIZE_W'(c);
            gen_value = SIZE_W'(cfg_seed % s);
            gen_ready = 1'b1;
        end
        emitted = gen_value;
        // advance against the size in force now, even if the held value exceeds it
        gen_value = SIZE_W'((longint'(gen_mult) * gen_value + gen_incr) % s);
        return emitted;
    endfunction

    // ---------------------------------------------------------------------
    // Monitor: registers, request and result transactions, watchdog.
    // Everything is sampled at the rising edge; inputs move on the falling one.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_size  = SIZE_W'(1);
            cfg_seed  = '0;
            gen_mult  = MULT_W'(1);
            gen_incr  = '0;
            gen_value = '0;
            gen_ready = 1'b0;
        end else begin
            idle_cycles++;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PATH_SIZE) cfg_size = i_cfg_data[SIZE_W-1:0];
                else cfg_seed = i_cfg_data[SEED_W-1:0];
            end
            if (i_in_valid && !o_in_stall) begin
                expected_indices.push_back(next_path_index(i_restart));
                idle_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                idle_cycles = 0;
                result_taken = 1'b1;
                if (expected_indices.size() == 0) begin
                    $error("index: unexpected result transaction, actual %0d", o_index);
                    error_count++;
                end else begin
                    logic [SIZE_W-1:0] want;
                    want = expected_indices.pop_front();
                    if (o_index !== want) begin
                        $error("index: expected %0d, actual %0d", want, o_index);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("full_period_lcg_index_path_tb: errors");
                $finish;
            end
        end
    end

    // Result-side stall: a random hold per transaction, plus an on-demand long
    // hold-off so the request side backs up and the block stalls its input.
    int stall_left = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (result_taken) begin
            stall_left = $urandom_range(0, max_stall_gap);
            result_taken = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Shared driving tasks
    // ---------------------------------------------------------------------
    // One request transaction; valid stays up across back-to-back items.
    task automatic send_request(bit restart);
        int gap;
        gap = $urandom_range(0, max_send_gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    // Drop valid, let every result arrive and the block settle
    task automatic drain_path();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        i_restart  <= 1'($urandom_range(0, 1));
        wait (expected_indices.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= CFG_W'($urandom);
    endtask

    task automatic set_path(int unsigned sz, int unsigned seed);
        write_reg(CFG_PATH_SIZE, CFG_W'(sz));
        write_reg(CFG_START_SEED, CFG_W'(seed));
    endtask

    // ---------------------------------------------------------------------
    // Test tasks
    // ---------------------------------------------------------------------
    // Reset values: size 1, seed 0; the first step restarts on its own.
    task automatic test_first_step_after_reset();
        send_request(1'b0);
        send_request(1'b0);
        drain_path();
    endtask

    // Size extremes: zero acts as one, oversize saturates, a prime near the cap
    // is the worst-case factoring and prime search, tiny sizes force increment 2.
    task automatic test_size_extremes();
        set_path(0, 5);                   send_request(1'b1); send_request(1'b0);
        drain_path();
        set_path('hFFFFFF, 'h7FFFFFFF);   send_request(1'b1); send_request(1'b0);
        drain_path();
        set_path(SIZE_CAP, 12345);        send_request(1'b1); send_request(1'b0);
        drain_path();
        set_path(9999991, 'h40000000);    send_request(1'b1); send_request(1'b0);
        drain_path();
        set_path(2, 1);                   send_request(1'b1); send_request(1'b0);
        drain_path();
        set_path(3, 'h7FFFFFFE);          send_request(1'b1); send_request(1'b0);
        drain_path();
        // divisible by four: multiplier kernel doubled
        set_path(64, 63);                 send_request(1'b1);
        repeat (3) send_request(1'b0);
        drain_path();
    endtask

    // Shrink the size without a restart: the held value is emitted as is
    // and reduced by the next advance.
    task automatic test_size_change_midpath();
        set_path(1000, 999);
        send_request(1'b1);
        send_request(1'b0);
        drain_path();
        write_reg(CFG_PATH_SIZE, CFG_W'(7));
        repeat (3) send_request(1'b0);
        drain_path();
    endtask

    // Long receiver hold-off while requests keep coming, no idling on the input
    task automatic test_backpressure();
        set_path(97, 31);
        max_send_gap = 0;
        hold_request = 1'b1;
        send_request(1'b1);
        repeat (20) send_request(1'b0);
        max_send_gap = 12;
        drain_path();
    endtask

    // Random phases, each with its own setting; mostly small sizes
    task automatic test_random_paths();
        int phase, n, sel;
        int unsigned sz;
        for (phase = 0; phase < 10; phase++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6)      sz = $urandom_range(1, 64);
            else if (sel < 9) sz = $urandom_range(65, 5000);
            else              sz = $urandom_range(5001, 100000);
            set_path(sz, $urandom);
            // every third phase runs with no idling on either side
            if (phase % 3 == 2) begin
                max_send_gap = 0;
                max_stall_gap = 0;
            end else begin
                max_send_gap = 12;
                max_stall_gap = 12;
            end
            for (n = 0; n < 83; n++)
                send_request($urandom_range(0, 9) == 0);
            drain_path();
        end
        max_send_gap = 12;
        max_stall_gap = 12;
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_first_step_after_reset();
        test_size_extremes();
        test_size_change_midpath();
        test_backpressure();
        test_random_paths();
        if (error_count == 0) begin
            $display("full_period_lcg_index_path_tb: clean");
        end else begin
            $display("full_period_lcg_index_path_tb: errors");
        end
        $finish;
    end

endmodule

FILE: full_period_lcg_index_path.f
src/fplcg_pkg.sv
src/fplcg_div.sv
src/full_period_lcg_index_path.sv
dv/full_period_lcg_index_path_tb.sv
